>>> sv/cbf_pkg.sv
// ----------------------------------------------------------------------------
// cbf_pkg
// Shared types and constants for the checksummed block framer.
// ----------------------------------------------------------------------------
package cbf_pkg;

    localparam int MAX_FRAME = 2048;

    // Largest payload length a block may carry: total never exceeds MAX_FRAME
    localparam int PAYLOAD_CAP_INT = ((MAX_FRAME - 5) > 2047) ? 2047 : (MAX_FRAME - 5);
    localparam logic [10:0] PAYLOAD_CAP = 11'(PAYLOAD_CAP_INT);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] CMD_DATA    = 2'd0;
    localparam logic [1:0] CMD_ACCEPT  = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    // One classified payload byte with everything the back end needs to emit it
    typedef struct packed {
        logic        hdr;     // first byte of a block: emit the length header
        logic [11:0] total;   // payload length plus 5
        logic [7:0]  data;
        logic        trl;     // last byte of a block: emit the trailer
        logic [7:0]  c0;
        logic [7:0]  c1;
        logic [7:0]  seq;
    } job_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HI,
        PH_LO,
        PH_DATA,
        PH_C0,
        PH_C1,
        PH_SEQ
    } phase_t;

endpackage

>>> sv/cbf_front.sv
// ----------------------------------------------------------------------------
// cbf_front
// Accepts input transfers, tracks block position and checksums, and hands
// one job per payload byte to the queue.
// ----------------------------------------------------------------------------
module cbf_front
    import cbf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [7:0]  data_byte,
    input  logic [10:0] payload_len,
    input  logic        q_full,
    output logic        push,
    output job_t        job
);

    logic [10:0] byte_position_reg, byte_position_next;
    logic [10:0] block_length_reg, block_length_next;
    logic [7:0]  xor_sum_reg, xor_sum_next;
    logic [7:0]  running_sum_reg, running_sum_next;
    logic [7:0]  sequence_number_reg, sequence_number_next;

    logic        accept;
    logic        first;
    logic        last;
    logic [10:0] len_eff;
    logic [10:0] blen;
    logic [7:0]  x_new;
    logic [7:0]  r_new;
    logic [10:0] pos_inc;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        first = (byte_position_reg == '0);
        if (payload_len == '0)
        begin
            len_eff = 11'd1;
        end
        else if (payload_len > PAYLOAD_CAP)
        begin
            len_eff = PAYLOAD_CAP;
        end
        else
        begin
            len_eff = payload_len;
        end
        blen    = first ? len_eff : block_length_reg;
        x_new   = (first ? 8'd0 : xor_sum_reg) ^ data_byte;
        r_new   = (first ? 8'd0 : running_sum_reg) + x_new;
        pos_inc = byte_position_reg + 11'd1;
        last    = (pos_inc >= blen);

        byte_position_next   = byte_position_reg;
        block_length_next    = block_length_reg;
        xor_sum_next         = xor_sum_reg;
        running_sum_next     = running_sum_reg;
        sequence_number_next = sequence_number_reg;
        push                 = 1'b0;

        job.hdr   = first;
        job.total = {1'b0, blen} + 12'd5;
        job.data  = data_byte;
        job.trl   = last;
        job.c0    = x_new;
        job.c1    = r_new;
        job.seq   = sequence_number_reg;

        if (accept)
        begin
            case (cmd)
                CMD_DATA:
                begin
                    push = 1'b1;
                    if (last)
                    begin
                        byte_position_next = '0;
                        block_length_next  = '0;
                        xor_sum_next       = '0;
                        running_sum_next   = '0;
                    end
                    else
                    begin
                        byte_position_next = pos_inc;
                        block_length_next  = blen;
                        xor_sum_next       = x_new;
                        running_sum_next   = r_new;
                    end
                end
                CMD_ACCEPT:
                begin
                    sequence_number_next = sequence_number_reg + 8'd1;
                end
                CMD_RESTART:
                begin
                    // drop the partial block and the session number
                    sequence_number_next = '0;
                    byte_position_next   = '0;
                    block_length_next    = '0;
                    xor_sum_next         = '0;
                    running_sum_next     = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg   <= '0;
            block_length_reg    <= '0;
            xor_sum_reg         <= '0;
            running_sum_reg     <= '0;
            sequence_number_reg <= '0;
        end
        else
        begin
            byte_position_reg   <= byte_position_next;
            block_length_reg    <= block_length_next;
            xor_sum_reg         <= xor_sum_next;
            running_sum_reg     <= running_sum_next;
            sequence_number_reg <= sequence_number_next;
        end
    end

endmodule

>>> sv/cbf_queue.sv
// ----------------------------------------------------------------------------
// cbf_queue
// Short job queue between front and back end.
// ----------------------------------------------------------------------------
module cbf_queue
    import cbf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t pop_job,
    output logic empty
);

    job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_job = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QPTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + QCNT_W'(1);
            2'b01:   count_next = count_reg - QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> sv/cbf_back.sv
// ----------------------------------------------------------------------------
// cbf_back
// Takes jobs from the queue and emits header, payload and trailer bytes,
// one output transfer per cycle while jobs are queued and out_ready is high.
// ----------------------------------------------------------------------------
module cbf_back
    import cbf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  job_t       q_job,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       frame_end
);

    phase_t phase_reg, phase_next;
    job_t   cur_reg, cur_next;
    logic   fin;

    always_comb
    begin
        phase_next = phase_reg;
        cur_next   = cur_reg;
        pop        = 1'b0;
        fin        = 1'b0;
        out_valid  = (phase_reg != PH_IDLE);
        frame_end  = (phase_reg == PH_SEQ);
        out_byte   = cur_reg.data;

        case (phase_reg)
            PH_IDLE:
            begin
                fin = 1'b1;
            end
            PH_HI:
            begin
                out_byte = {4'b0, cur_reg.total[11:8]};
                if (out_ready)
                begin
                    phase_next = PH_LO;
                end
            end
            PH_LO:
            begin
                out_byte = cur_reg.total[7:0];
                if (out_ready)
                begin
                    phase_next = PH_DATA;
                end
            end
            PH_DATA:
            begin
                out_byte = cur_reg.data;
                if (out_ready)
                begin
                    if (cur_reg.trl)
                    begin
                        phase_next = PH_C0;
                    end
                    else
                    begin
                        fin = 1'b1;
                    end
                end
            end
            PH_C0:
            begin
                out_byte = cur_reg.c0;
                if (out_ready)
                begin
                    phase_next = PH_C1;
                end
            end
            PH_C1:
            begin
                out_byte = cur_reg.c1;
                if (out_ready)
                begin
                    phase_next = PH_SEQ;
                end
            end
            PH_SEQ:
            begin
                out_byte = cur_reg.seq;
                if (out_ready)
                begin
                    fin = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        // load the next job in the same cycle the current one finishes
        if (fin)
        begin
            if (!q_empty)
            begin
                pop        = 1'b1;
                cur_next   = q_job;
                phase_next = q_job.hdr ? PH_HI : PH_DATA;
            end
            else
            begin
                phase_next = PH_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

endmodule

>>> sv/checksummed_block_framer.sv
// ----------------------------------------------------------------------------
// checksummed_block_framer
// Frames a payload byte stream into length-prefixed blocks with XOR and
// running-sum checksums and a session packet number.
// ----------------------------------------------------------------------------
// Throughput: one input transfer per cycle while the queue has room; one output
// byte per cycle while jobs are queued and the sink is ready. The back end emits
// two header bytes before a block's first payload byte and three trailer bytes
// after its last; its output sequencer sets the output rate, and a 4-entry queue
// decouples it from the input. Reset clears position, checksums, length and
// packet number to zero and empties the queue.
// ----------------------------------------------------------------------------
module checksummed_block_framer
    import cbf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [7:0] data_byte, [18:8] payload_len, rest zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast    // frame_end
);

    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    job_t push_job;
    job_t pop_job;

    cbf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .cmd         (s_axis_tuser),
        .data_byte   (s_axis_tdata[7:0]),
        .payload_len (s_axis_tdata[18:8]),
        .q_full      (q_full),
        .push        (push),
        .job         (push_job)
    );

    cbf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    cbf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_job     (pop_job),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .frame_end (m_axis_tlast)
    );

endmodule

>>> dv/cbf_checker.sv
// ----------------------------------------------------------------------------
// cbf_checker
// Watches both stream ports of the block framer, predicts every framed byte
// from the accepted input transfers and compares the output transfers
// against them in order.
// ----------------------------------------------------------------------------
module cbf_checker
    import cbf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,    // [7:0] data_byte, [18:8] payload_len, rest zero
    input  logic [1:0]  s_tuser,    // [1:0] cmd
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,    // [7:0] out_byte
    input  logic        m_tlast,    // frame_end
    output int          fail_count,
    output int          bytes_pending,
    output int          bytes_checked,
    output int          frames_closed
);

    localparam int PRINT_LIMIT = 20;

    typedef struct packed {
        logic [7:0] val;
        logic       last;
    } framed_byte_t;

    framed_byte_t framed_bytes_q[$];
    framed_byte_t want;

    // Mirror of the framer state
    logic [10:0] taken;
    logic [10:0] block_len;
    logic [7:0]  c0_acc;
    logic [7:0]  c1_acc;
    logic [7:0]  pkt_num;

    int errors;
    int checked;
    int frames;

    assign fail_count = errors;

    task automatic flag_mismatch(input string msg);
        if (errors < PRINT_LIMIT)
            $display("MISMATCH @%0t: %s", $time, msg);
        errors++;
    endtask

    // Fold one input transfer into the mirror and queue the bytes it produces
    task automatic frame_input(input logic [1:0] cmd, input logic [7:0] data,
                               input logic [10:0] len_field);
        logic [15:0] total;
        if (cmd == CMD_ACCEPT)
        begin
            pkt_num = pkt_num + 8'd1;
        end
        else if (cmd == CMD_RESTART)
        begin
            pkt_num   = '0;
            taken     = '0;
            block_len = '0;
            c0_acc    = '0;
            c1_acc    = '0;
        end
        else if (cmd == CMD_DATA)
        begin
            if (taken == '0)
            begin
                block_len = (len_field == '0) ? 11'd1 : len_field;
                if (block_len > PAYLOAD_CAP)
                    block_len = PAYLOAD_CAP;
                c0_acc = '0;
                c1_acc = '0;
                total  = 16'(block_len) + 16'd5;
                framed_bytes_q.push_back('{val: total[15:8], last: 1'b0});
                framed_bytes_q.push_back('{val: total[7:0], last: 1'b0});
            end
            framed_bytes_q.push_back('{val: data, last: 1'b0});
            c0_acc = c0_acc ^ data;
            c1_acc = c1_acc + c0_acc;
            taken  = taken + 11'd1;
            if (taken >= block_len)
            begin
                framed_bytes_q.push_back('{val: c0_acc, last: 1'b0});
                framed_bytes_q.push_back('{val: c1_acc, last: 1'b0});
                framed_bytes_q.push_back('{val: pkt_num, last: 1'b1});
                taken     = '0;
                block_len = '0;
                c0_acc    = '0;
                c1_acc    = '0;
            end
        end
        // the unused command code leaves everything alone
    endtask

    initial
    begin
        errors  = 0;
        checked = 0;
        frames  = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            framed_bytes_q.delete();
            taken         = '0;
            block_len     = '0;
            c0_acc        = '0;
            c1_acc        = '0;
            pkt_num       = '0;
            bytes_pending <= 0;
            bytes_checked <= 0;
            frames_closed <= 0;
        end
        else
        begin
            // queue the new expectations before checking this edge's output transfer
            if (s_tvalid && s_tready)
                frame_input(s_tuser, s_tdata[7:0], s_tdata[18:8]);

            if (m_tvalid && m_tready)
            begin
                if (framed_bytes_q.size() == 0)
                begin
                    flag_mismatch($sformatf("unexpected byte %02h last=%0b",
                                            m_tdata, m_tlast));
                end
                else
                begin
                    want = framed_bytes_q.pop_front();
                    if (m_tdata !== want.val)
                        flag_mismatch($sformatf("byte %0d: out_byte %02h, want %02h",
                                                checked, m_tdata, want.val));
                    if (m_tlast !== want.last)
                        flag_mismatch($sformatf("byte %0d: frame_end %0b, want %0b",
                                                checked, m_tlast, want.last));
                    checked++;
                end
                if (m_tlast === 1'b1)
                    frames++;
            end

            bytes_pending <= framed_bytes_q.size();
            bytes_checked <= checked;
            frames_closed <= frames;
        end
    end

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the block framer with directed and random payload, accept, restart
// and unused-command transfers under random gaps and back-pressure; the
// checker beside the block predicts and compares every framed byte.
// ----------------------------------------------------------------------------
module testbench
    import cbf_pkg::*;
();

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS  = 180;
    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 20;

    logic        clk;
    logic        rst_n;
    logic        s_valid;
    logic        s_ready;
    logic [23:0] s_data;    // [7:0] data_byte, [18:8] payload_len, rest zero
    logic [1:0]  s_user;    // [1:0] cmd
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_data;    // [7:0] out_byte
    logic        m_last;    // frame_end

    int fail_count;
    int bytes_pending;
    int bytes_checked;
    int frames_closed;

    bit src_gaps;
    bit sink_stalls;
    int stall_left;
    int idle_cycles;
    int n_payload;
    int n_accept;
    int n_restart;
    int n_unused;

    checksummed_block_framer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tlast  (m_last)
    );

    cbf_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_valid),
        .s_tready      (s_ready),
        .s_tdata       (s_data),
        .s_tuser       (s_user),
        .m_tvalid      (m_valid),
        .m_tready      (m_ready),
        .m_tdata       (m_data),
        .m_tlast       (m_last),
        .fail_count    (fail_count),
        .bytes_pending (bytes_pending),
        .bytes_checked (bytes_checked),
        .frames_closed (frames_closed)
    );

    initial
        clk = 1'b0;

    always #1 clk = ~clk;

    // Mostly short idle stretches, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 92)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Output back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (sink_stalls && $urandom_range(0, 99) < 20)
        begin
            m_ready    <= 1'b0;
            stall_left <= idle_len() - 1;
        end
        else
        begin
            m_ready <= 1'b1;
        end
    end

    // End the run if no transfer happens on either port for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Watchdog: no transfer for %0d cycles, %0d bytes still expected",
                     idle_cycles, bytes_pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Present one item and hold it until the transfer; valid stays high afterwards
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] data,
                             input logic [10:0] len_field);
        int gap;
        gap = (src_gaps && $urandom_range(0, 99) < 25) ? idle_len() : 0;
        if (gap > 0)
        begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_user  <= cmd;
        s_data  <= {5'b0, len_field, data};
        do
            @(posedge clk);
        while (!s_ready);
        case (cmd)
            CMD_DATA:    n_payload++;
            CMD_ACCEPT:  n_accept++;
            CMD_RESTART: n_restart++;
            default:     n_unused++;
        endcase
    endtask

    // Hold off the input until every expected byte has come out
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge clk);
        while (bytes_pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [10:0] any_len();
        return 11'($urandom_range(0, 2047));
    endfunction

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Blocks of random content, mostly short, with accepts, restarts and noise
    task automatic random_blocks(input int n_items);
        int start;
        int nbytes;
        int r;
        int i;
        bit abandon;
        logic [10:0] first_len;
        start = n_payload + n_accept + n_restart;
        while (n_payload + n_accept + n_restart - start < n_items)
        begin
            r = $urandom_range(0, 99);
            if (r < 85)
                nbytes = $urandom_range(1, 6);
            else if (r < 97)
                nbytes = $urandom_range(7, 32);
            else
                nbytes = $urandom_range(250, 270);
            first_len = 11'(nbytes);
            abandon   = 1'b0;
            r = $urandom_range(0, 99);
            if (r < 4)
            begin
                first_len = '0;
                nbytes    = 1;
            end
            else if (r < 7)
            begin
                // oversize length: send a little, then give up on the block
                first_len = 11'($urandom_range(2044, 2047));
                nbytes    = $urandom_range(1, 5);
                abandon   = 1'b1;
            end
            else if (r < 10)
            begin
                abandon = 1'b1;
                nbytes  = $urandom_range(1, nbytes);
                first_len = 11'(nbytes + $urandom_range(1, 8));
            end
            for (i = 0; i < nbytes; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    send_item(CMD_ACCEPT, any_byte(), any_len());
                else if (r < 5)
                    send_item(CMD_UNUSED, any_byte(), any_len());
                send_item(CMD_DATA, any_byte(), (i == 0) ? first_len : any_len());
            end
            if (abandon)
                send_item(CMD_RESTART, any_byte(), any_len());
            r = $urandom_range(0, 99);
            if (r < 60)
                send_item(CMD_ACCEPT, any_byte(), any_len());
            else if (r < 63)
                send_item(CMD_RESTART, any_byte(), any_len());
            else if (r < 66)
                send_item(CMD_UNUSED, any_byte(), any_len());
        end
    endtask

    initial
    begin
        int i;
        int n_wrap;
        rst_n       <= 1'b0;
        s_valid     <= 1'b0;
        s_data      <= '0;
        s_user      <= CMD_DATA;
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        n_payload   = 0;
        n_accept    = 0;
        n_restart   = 0;
        n_unused    = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: one-byte block, zero length, three-byte block
        send_item(CMD_DATA, 8'h00, 11'd1);
        send_item(CMD_DATA, 8'hFF, 11'd0);
        send_item(CMD_ACCEPT, 8'h00, 11'd0);
        send_item(CMD_DATA, 8'hA5, 11'd3);
        send_item(CMD_DATA, 8'h5A, 11'd0);
        send_item(CMD_DATA, 8'hFF, 11'h7FF);
        // oversize length, unused command and restart in the middle of a block
        send_item(CMD_DATA, 8'h3C, 11'h7FF);
        send_item(CMD_DATA, 8'hC3, 11'd5);
        send_item(CMD_UNUSED, 8'hFF, 11'h7FF);
        send_item(CMD_RESTART, 8'h00, 11'd0);
        // accept in the middle of a block: the trailer carries the new number
        send_item(CMD_DATA, 8'h80, 11'd2);
        send_item(CMD_ACCEPT, 8'h00, 11'd0);
        send_item(CMD_DATA, 8'h01, 11'd0);
        drain();
        send_item(CMD_DATA, 8'h7E, 11'd4);
        send_item(CMD_DATA, 8'h7E, 11'd1);
        send_item(CMD_DATA, 8'h81, 11'd2);
        send_item(CMD_DATA, 8'hFF, 11'd3);
        send_item(CMD_ACCEPT, 8'h00, 11'd0);
        send_item(CMD_DATA, 8'h55, 11'd2043);
        send_item(CMD_DATA, 8'hAA, 11'd9);
        send_item(CMD_RESTART, 8'h00, 11'd0);
        send_item(CMD_DATA, 8'h12, 11'd2);
        send_item(CMD_DATA, 8'h34, 11'd2);

        // Random with gaps and stalls on both sides
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        random_blocks(RANDOM_ITEMS / 3);
        drain();

        // Wrap the packet number, then run at full rate
        n_wrap = $urandom_range(256, 262);
        for (i = 0; i < n_wrap; i++)
            send_item(CMD_ACCEPT, any_byte(), any_len());
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        random_blocks(RANDOM_ITEMS / 3);

        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        random_blocks(RANDOM_ITEMS / 3);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d payload bytes, %0d accepts, %0d restarts, %0d unused commands.",
                 n_payload, n_accept, n_restart, n_unused);
        $display("Checked %0d framed bytes across %0d closed frames.",
                 bytes_checked, frames_closed);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> sim.f
sv/cbf_pkg.sv
sv/cbf_front.sv
sv/cbf_queue.sv
sv/cbf_back.sv
sv/checksummed_block_framer.sv
dv/cbf_checker.sv
dv/testbench.sv
